// File: src/kpd_pkg.sv
// kpd_pkg: shared types and constants for the KMP period detector.
// No dependencies; every other file of the block but kpd_rem uses it.
package kpd_pkg;

    localparam int CHAR_W  = 8;   // one string byte
    localparam int FIELD_W = 11;  // period and length result fields

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DSTART,
        S_DIV,
        S_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take;       // input item accepted this cycle
        logic step;       // follow one failure link
        logic commit;     // write border entry, advance position
        logic div_start;  // launch length % period
        logic load_out;   // fill result register, clear string state
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pos_zero;   // no byte stored yet
        logic pos_full;   // store full, next byte is dropped
        logic scan_done;  // border walk ends this cycle
        logic last;       // held last flag of the byte in work
        logic div_busy;   // remainder unit running
        logic out_busy;   // result register holds an item not taken
    } t_dp_sts;

endpackage

// File: src/kpd_in_if.sv
// kpd_in_if: input channel, one string byte and its last flag per item.
// Depends on kpd_pkg.
interface kpd_in_if;
    logic                        valid;
    logic                        ready;
    logic [kpd_pkg::CHAR_W-1:0]  char_code;
    logic                        last;

    modport source (output valid, char_code, last, input ready);
    modport sink   (input valid, char_code, last, output ready);
endinterface

// File: src/kpd_out_if.sv
// kpd_out_if: result channel, one item per string.
// Depends on kpd_pkg.
interface kpd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        repeated;
    logic [kpd_pkg::FIELD_W-1:0] period;
    logic [kpd_pkg::FIELD_W-1:0] length;
    logic                        overflow;

    modport source (output valid, repeated, period, length, overflow, input ready);
    modport sink   (input valid, repeated, period, length, overflow, output ready);
endinterface

// File: src/kmp_period_detector.sv
// kmp_period_detector: top level, joins controller and datapath to the channels.
// Depends on kpd_pkg, kpd_in_if, kpd_out_if, kpd_ctrl, kpd_datapath.
//
// Usage: strings arrive on i_in one byte per item, last = 1 on the final
// byte. Each string yields exactly one item on o_out: repeated, period
// (length minus final border), length (bytes stored) and overflow.
// Bytes past MAX_LEN are dropped and set overflow, which forces repeated = 0.
// Timing: i_in.ready is high only while the sequencer is idle. A stored byte
// past the first walks the failure links of the border table before the next
// byte is taken; a dropped byte or the first byte of a string needs no walk.
// After the last byte the remainder unit runs one bit per cycle over the
// PW = clog2(MAX_LEN + 1) bits of the length (11 at the default); the
// result is then loaded, and the next string can start right after the load.
// Stall: the result register holds an item until o_out.ready; the next
// string streams in meanwhile and its result waits until the slot frees.
// Reset (synchronous, active low) clears the counters and the result valid;
// the byte and border stores need no clearing, only entries written for the
// current string are read.
module kmp_period_detector #(
    parameter int MAX_LEN = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kpd_in_if.sink    i_in,
    kpd_out_if.source o_out
);
    kpd_pkg::t_dp_cmd cmd;
    kpd_pkg::t_dp_sts sts;

    kpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    kpd_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_char      (i_in.char_code),
        .i_last      (i_in.last),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .o_repeated  (o_out.repeated),
        .o_period    (o_out.period),
        .o_length    (o_out.length),
        .o_overflow  (o_out.overflow)
    );

`ifndef NO_ASSERTIONS
    // a result load frees the sequencer and shows the item at once
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_out.valid && i_in.ready)
        else $error("result load did not reach the output");

    // no intake while the remainder unit runs
    a_div_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.div_busy |-> !i_in.ready)
        else $error("input ready during remainder");

    // a stored byte past the first always walks the border table
    a_take_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !sts.pos_full && !sts.pos_zero) |=> !i_in.ready)
        else $error("border walk skipped");

    // overflowed strings never report a repetition
    a_rep_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.repeated) |-> !o_out.overflow)
        else $error("repeated set on overflowed string");
`endif

endmodule

// File: src/kpd_rem.sv
// kpd_rem: bit-serial restoring remainder unit, one quotient bit per cycle.
// No package dependencies.
module kpd_rem #(
    parameter int W = 11
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_busy,
    output logic         o_rem_zero
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_num;
    logic [W-1:0]  r_den;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic [W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_num[W-1]};
        diff  = trial - {1'b0, r_den};
        n_rem = (trial >= {1'b0, r_den}) ? diff[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= r_num << 1;
        end
    end

    assign o_busy     = r_busy;
    assign o_rem_zero = (r_rem == '0);

endmodule

// File: src/kpd_datapath.sv
// kpd_datapath: byte store, border table, border walk, remainder unit, result register.
// Depends on kpd_pkg and kpd_rem.
module kpd_datapath #(
    parameter int MAX_LEN = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kpd_pkg::t_dp_cmd             i_cmd,
    input  logic [kpd_pkg::CHAR_W-1:0]   i_char,
    input  logic                         i_last,
    input  logic                         i_out_ready,
    output kpd_pkg::t_dp_sts             o_sts,
    output logic                         o_out_valid,
    output logic                         o_repeated,
    output logic [kpd_pkg::FIELD_W-1:0]  o_period,
    output logic [kpd_pkg::FIELD_W-1:0]  o_length,
    output logic                         o_overflow
);
    localparam int IW = $clog2(MAX_LEN);      // store index
    localparam int PW = $clog2(MAX_LEN + 1);  // byte count

    logic [kpd_pkg::CHAR_W-1:0] r_cs_mem [MAX_LEN];
    logic [IW-1:0]              r_bt_mem [MAX_LEN];

    logic [PW-1:0]              r_pos;
    logic [IW-1:0]              r_brd;
    logic                       r_ovf;
    logic [kpd_pkg::CHAR_W-1:0] r_char;
    logic                       r_last;
    logic [IW-1:0]              r_j;
    logic [kpd_pkg::CHAR_W-1:0] r_cs_q;
    logic [IW-1:0]              r_bt_q;

    logic                        r_out_valid;
    logic                        r_out_rep;
    logic [kpd_pkg::FIELD_W-1:0] r_out_per;
    logic [kpd_pkg::FIELD_W-1:0] r_out_len;
    logic                        r_out_ovf;

    logic [IW-1:0] pos_idx;
    logic          pos_full;
    logic          pos_zero;
    logic          match;
    logic [IW-1:0] j_ext;
    logic [IW-1:0] seed_j;
    logic [IW-1:0] link_j;
    logic [IW-1:0] n_j;
    logic          rd_en;
    logic [PW-1:0] per;
    logic          div_busy;
    logic          rem_zero;

    always_comb begin
        pos_idx  = r_pos[IW-1:0];
        pos_full = (r_pos == PW'(MAX_LEN));
        pos_zero = (r_pos == '0);
        match    = (r_cs_q == r_char);
        j_ext    = r_j + IW'(match);
        seed_j   = (PW'(r_brd) >= r_pos) ? '0 : r_brd;
        link_j   = (PW'(r_bt_q) >= r_pos) ? '0 : r_bt_q;
        n_j      = i_cmd.take ? seed_j : link_j;
        rd_en    = (i_cmd.take && !pos_full && !pos_zero) || i_cmd.step;
        per      = (PW'(r_brd) < r_pos) ? (r_pos - PW'(r_brd)) : r_pos;
    end

    // store writes and registered reads; a write and a read never share an address
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && !pos_full) begin
            r_cs_mem[pos_idx] <= i_char;
        end
        if (i_cmd.take && pos_zero) begin
            r_bt_mem[0] <= '0;
        end else if (i_cmd.commit) begin
            r_bt_mem[pos_idx] <= j_ext;
        end
        if (rd_en) begin
            r_cs_q <= r_cs_mem[n_j];
            if (n_j != '0) begin
                r_bt_q <= r_bt_mem[n_j - IW'(1)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_brd <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_pos <= '0;
            r_brd <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.take) begin
            if (pos_full) begin
                r_ovf <= 1'b1;
            end else if (pos_zero) begin
                r_pos <= PW'(1);
                r_brd <= '0;
            end
        end else if (i_cmd.commit) begin
            r_brd <= j_ext;
            r_pos <= r_pos + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_char <= i_char;
            r_last <= i_last;
        end
        if (i_cmd.take || i_cmd.step) begin
            r_j <= n_j;
        end
    end

    kpd_rem #(
        .W (PW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_num      (r_pos),
        .i_den      (per),
        .o_busy     (div_busy),
        .o_rem_zero (rem_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_rep <= !r_ovf && (r_brd != '0) && rem_zero;
            r_out_per <= kpd_pkg::FIELD_W'(per);
            r_out_len <= kpd_pkg::FIELD_W'(r_pos);
            r_out_ovf <= r_ovf;
        end
    end

    always_comb begin
        o_sts.pos_zero  = pos_zero;
        o_sts.pos_full  = pos_full;
        o_sts.scan_done = (r_j == '0) || match;
        o_sts.last      = r_last;
        o_sts.div_busy  = div_busy;
        o_sts.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_repeated  = r_out_rep;
    assign o_period    = r_out_per;
    assign o_length    = r_out_len;
    assign o_overflow  = r_out_ovf;

endmodule

// File: src/kpd_ctrl.sv
// kpd_ctrl: sequencer for byte intake, border walk, remainder and result load.
// Depends on kpd_pkg.
module kpd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  kpd_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output kpd_pkg::t_dp_cmd o_cmd
);
    kpd_pkg::t_state r_state;
    kpd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kpd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            kpd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.pos_full || i_sts.pos_zero) begin
                        n_state = i_in_last ? kpd_pkg::S_DSTART : kpd_pkg::S_IDLE;
                    end else begin
                        n_state = kpd_pkg::S_SCAN;
                    end
                end
            end
            kpd_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = i_sts.last ? kpd_pkg::S_DSTART : kpd_pkg::S_IDLE;
                end
            end
            kpd_pkg::S_DSTART: begin
                n_state = kpd_pkg::S_DIV;
            end
            kpd_pkg::S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = kpd_pkg::S_EMIT;
                end
            end
            kpd_pkg::S_EMIT: begin
                if (!i_sts.out_busy) begin
                    n_state = kpd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kpd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.take      = 1'b0;
        o_cmd.step      = 1'b0;
        o_cmd.commit    = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            kpd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            kpd_pkg::S_SCAN: begin
                o_cmd.step   = !i_sts.scan_done;
                o_cmd.commit = i_sts.scan_done;
            end
            kpd_pkg::S_DSTART: begin
                o_cmd.div_start = 1'b1;
            end
            kpd_pkg::S_DIV: begin
            end
            kpd_pkg::S_EMIT: begin
                o_cmd.load_out = !i_sts.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule
